>>> hw/rtl/bfs_shortest_hop_count_defines.svh
// Assertion macros shared by the shortest-hop-count RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BFS_SHORTEST_HOP_COUNT_DEFINES_SVH
`define BFS_SHORTEST_HOP_COUNT_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define BFS_ASSERT_ALWAYS(LBL, CLK, RSTN, COND, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (COND)) else $error(MSG);

// consequent must hold in the same cycle as the antecedent
`define BFS_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) else $error(MSG);

// consequent must hold in the cycle after the antecedent
`define BFS_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) else $error(MSG);

`endif

>>> hw/rtl/bfs_pkg.sv
// Shared types and codes for the shortest-hop-count block.
// No dependencies; imported by bfs_tab, bfs_eng and the top level.
`default_nettype none

package bfs_pkg;

	// width of node ids and hop counts on the ports
	localparam int ID_W      = 6;
	localparam int HOP_LIMIT = 63;

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// one passage slot of the adjacency table
	typedef struct packed {
		logic [ID_W-1:0] dest;
		logic            present;
		logic            is_open;
	} entry_t;

	// query request handed to the search engine
	typedef struct packed {
		logic            go;
		logic [ID_W-1:0] start;
		logic [ID_W-1:0] goal;
	} eng_req_t;

	// result handed back by the search engine
	typedef struct packed {
		logic            done;
		logic [ID_W-1:0] hops;
		logic            reach;
	} eng_res_t;

	// search sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POP,
		ST_BASE,
		ST_RDTAB,
		ST_RDVIS,
		ST_EVAL,
		ST_FIN
	} eng_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bfs_tab.sv
// Passage table: one write port, one registered read port, clearing sweep after reset.
// Depends on bfs_pkg (entry_t).
`default_nettype none

module bfs_tab #(
	parameter int MAX_NODES      = 64,
	parameter int SLOTS_PER_NODE = 4,
	parameter int TAB_W          = $clog2(MAX_NODES * SLOTS_PER_NODE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	output logic                 clearing,
	input  logic                 wr_en,
	input  logic [TAB_W-1:0]     wr_addr,
	input  bfs_pkg::entry_t      wr_data,
	input  logic                 rd_en,
	input  logic [TAB_W-1:0]     rd_addr,
	output bfs_pkg::entry_t      rd_data
);
	import bfs_pkg::*;

	localparam int DEPTH = MAX_NODES * SLOTS_PER_NODE;

	entry_t             mem [DEPTH];
	entry_t             rd_data_q;
	logic               clearing_q;
	logic [TAB_W-1:0]   clr_addr_q;

	// clearing sweep: one slot per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == TAB_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;
	assign rd_data  = rd_data_q;

endmodule

`default_nettype wire

>>> hw/rtl/bfs_eng.sv
// Breadth-first search engine: sequencer, visited marks and frontier queue.
// Depends on bfs_pkg; reads the passage table held in bfs_tab.
`default_nettype none
`include "bfs_shortest_hop_count_defines.svh"

module bfs_eng #(
	parameter int MAX_NODES      = 64,
	parameter int SLOTS_PER_NODE = 4,
	parameter int NODE_W         = $clog2(MAX_NODES),
	parameter int TAB_W          = $clog2(MAX_NODES * SLOTS_PER_NODE)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfs_pkg::eng_req_t  req,
	input  logic               res_room,
	output logic               idle,
	output logic               tab_rd_en,
	output logic [TAB_W-1:0]   tab_rd_addr,
	input  bfs_pkg::entry_t    tab_rd_data,
	output bfs_pkg::eng_res_t  res
);
	import bfs_pkg::*;

	localparam int SLOT_W = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
	localparam int CNT_W  = NODE_W + 1;
	localparam int QE_W   = 2 * NODE_W;

	eng_state_t          state_q, state_d;
	logic [NODE_W-1:0]   start_q, goal_q, clr_q, u_hop_q;
	logic [CNT_W-1:0]    head_q, tail_q;
	logic [TAB_W-1:0]    addr_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [ID_W-1:0]     hops_q;
	logic                reach_q;

	// visited marks and frontier queue (node, hop)
	logic                vis_mem [MAX_NODES];
	logic                vis_rd_q;
	logic [QE_W-1:0]     q_mem [MAX_NODES];
	logic [QE_W-1:0]     q_rd_q;

	logic                req_ok, req_same, usable, last_slot, q_empty, clr_last, is_goal;
	logic                fresh;
	logic [NODE_W-1:0]   dest_n, new_hop;
	logic [ID_W-1:0]     hop_sat;
	logic                vis_we, vis_wd, vis_re;
	logic [NODE_W-1:0]   vis_wa;
	logic                q_we, q_re;
	logic [NODE_W-1:0]   q_wa;
	logic [QE_W-1:0]     q_wd;

	// decode of the current step
	always_comb begin
		req_ok    = (32'(req.start) < MAX_NODES) && (32'(req.goal) < MAX_NODES);
		req_same  = req.start == req.goal;
		usable    = tab_rd_data.present && tab_rd_data.is_open &&
			(32'(tab_rd_data.dest) < MAX_NODES);
		dest_n    = NODE_W'(tab_rd_data.dest);
		new_hop   = u_hop_q + 1'b1;
		hop_sat   = (32'(new_hop) > HOP_LIMIT) ? ID_W'(HOP_LIMIT) : ID_W'(new_hop);
		last_slot = slot_q == SLOT_W'(SLOTS_PER_NODE - 1);
		q_empty   = head_q == tail_q;
		clr_last  = clr_q == NODE_W'(MAX_NODES - 1);
		is_goal   = dest_n == goal_q;
		fresh     = !vis_rd_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.go) begin
					state_d = (!req_ok || req_same) ? ST_FIN : ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (clr_last) state_d = ST_POP;
			end
			ST_POP: begin
				state_d = q_empty ? ST_FIN : ST_BASE;
			end
			ST_BASE: state_d = ST_RDTAB;
			ST_RDTAB: state_d = ST_RDVIS;
			ST_RDVIS: begin
				if (usable) state_d = ST_EVAL;
				else if (last_slot) state_d = ST_POP;
				else state_d = ST_RDTAB;
			end
			ST_EVAL: begin
				if (fresh && is_goal) state_d = ST_FIN;
				else if (last_slot) state_d = ST_POP;
				else state_d = ST_RDTAB;
			end
			ST_FIN: begin
				if (res_room) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory strobes and handshake outputs
	always_comb begin
		idle        = state_q == ST_IDLE;
		tab_rd_en   = state_q == ST_RDTAB;
		tab_rd_addr = addr_q;
		vis_we      = 1'b0;
		vis_wa      = clr_q;
		vis_wd      = 1'b0;
		vis_re      = state_q == ST_RDVIS;
		q_we        = 1'b0;
		q_wa        = '0;
		q_wd        = {start_q, NODE_W'(0)};
		q_re        = state_q == ST_POP;
		res.done    = (state_q == ST_FIN) && res_room;
		res.hops    = hops_q;
		res.reach   = reach_q;
		case (state_q)
			ST_CLEAR: begin
				// start node counts as visited from the outset
				vis_we = 1'b1;
				vis_wd = clr_q == start_q;
				q_we   = clr_q == '0;
			end
			ST_EVAL: begin
				vis_we = fresh;
				vis_wa = dest_n;
				vis_wd = 1'b1;
				q_we   = fresh && !is_goal && (32'(tail_q) < MAX_NODES);
				q_wa   = tail_q[NODE_W-1:0];
				q_wd   = {dest_n, new_hop};
			end
			default: begin
			end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		if (vis_re) vis_rd_q <= vis_mem[dest_n];
		if (q_we) q_mem[q_wa] <= q_wd;
		if (q_re) q_rd_q <= q_mem[head_q[NODE_W-1:0]];
	end

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= '0;
			goal_q  <= '0;
			clr_q   <= '0;
			u_hop_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			addr_q  <= '0;
			slot_q  <= '0;
			hops_q  <= '0;
			reach_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (req.go) begin
						start_q <= NODE_W'(req.start);
						goal_q  <= NODE_W'(req.goal);
						clr_q   <= '0;
						head_q  <= '0;
						tail_q  <= CNT_W'(1);
						hops_q  <= '0;
						reach_q <= req_ok && req_same;
					end
				end
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_POP: begin
					if (!q_empty) head_q <= head_q + 1'b1;
				end
				ST_BASE: begin
					u_hop_q <= q_rd_q[NODE_W-1:0];
					addr_q  <= TAB_W'(32'(q_rd_q[QE_W-1:NODE_W]) * SLOTS_PER_NODE);
					slot_q  <= '0;
				end
				ST_RDVIS: begin
					if (!usable && !last_slot) begin
						slot_q <= slot_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_EVAL: begin
					if (fresh && is_goal) begin
						hops_q  <= hop_sat;
						reach_q <= 1'b1;
					end else if (fresh && (32'(tail_q) < MAX_NODES)) begin
						tail_q <= tail_q + 1'b1;
					end
					if (!last_slot) begin
						slot_q <= slot_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// checks
	`BFS_ASSERT_ALWAYS(a_head_le_tail, clk, arst_n, head_q <= tail_q, "queue head passed tail")
	`BFS_ASSERT_ALWAYS(a_tail_bound, clk, arst_n, 32'(tail_q) <= MAX_NODES, "queue overfilled")
	`BFS_ASSERT_NEXT(a_done_idle, clk, arst_n, res.done, state_q == ST_IDLE, "no idle after result")
	`BFS_ASSERT_NEXT(a_goal_found, clk, arst_n, (state_q == ST_EVAL) && fresh && is_goal, (state_q == ST_FIN) && reach_q, "goal hit not reported")

endmodule

`default_nettype wire

>>> hw/rtl/bfs_shortest_hop_count.sv
// Shortest hop count by breadth-first search. A write request (req_type 0) sets one
// passage slot; out-of-range node or slot writes are dropped. A query (req_type 1)
// returns one result: hop_count and reachable. Start equal to goal, or start/goal
// out of range, answers without a search. A full search first clears the visited
// marks, then for each node taken off the frontier reads each of its slots from the
// passage table and then the visited mark of its destination, and evaluates each
// usable slot; the pace is set by the single read port of the passage table and of
// the visited marks. in_ready stays low during a query. After reset the table is
// cleared one slot per cycle before the first request is taken. A result waits in
// the output register while writes are still accepted. Depends on bfs_pkg, bfs_tab
// and bfs_eng.
`default_nettype none

module bfs_shortest_hop_count #(
	parameter int MAX_NODES      = 64,
	parameter int SLOTS_PER_NODE = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [bfs_pkg::ID_W-1:0]   node_index,
	input  logic [1:0]                 slot_index,
	input  logic [bfs_pkg::ID_W-1:0]   neighbour_node,
	input  logic                       passage_present,
	input  logic                       passage_open,
	input  logic [bfs_pkg::ID_W-1:0]   start_node,
	input  logic [bfs_pkg::ID_W-1:0]   goal_node,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bfs_pkg::ID_W-1:0]   hop_count,
	output logic                       reachable
);
	import bfs_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int TAB_W  = $clog2(MAX_NODES * SLOTS_PER_NODE);

	logic              tab_clearing, eng_idle, accept, res_room;
	logic              tab_wr_en, tab_rd_en;
	logic [TAB_W-1:0]  tab_wr_addr, tab_rd_addr;
	entry_t            tab_wr_data, tab_rd_data;
	eng_req_t          eng_req;
	eng_res_t          eng_res;
	logic              out_valid_q, reachable_q;
	logic [ID_W-1:0]   hop_count_q;

	// request decode
	always_comb begin
		in_ready    = !tab_clearing && eng_idle;
		accept      = in_valid && in_ready;
		tab_wr_en   = accept && (req_type == REQ_WRITE) &&
			(32'(node_index) < MAX_NODES) && (32'(slot_index) < SLOTS_PER_NODE);
		tab_wr_addr = TAB_W'(32'(node_index) * SLOTS_PER_NODE + 32'(slot_index));
		tab_wr_data.dest    = neighbour_node;
		tab_wr_data.present = passage_present;
		tab_wr_data.is_open = passage_open;
		eng_req.go    = accept && (req_type == REQ_QUERY);
		eng_req.start = start_node;
		eng_req.goal  = goal_node;
		res_room      = !out_valid_q || out_ready;
	end

	bfs_tab #(
		.MAX_NODES      (MAX_NODES),
		.SLOTS_PER_NODE (SLOTS_PER_NODE),
		.TAB_W          (TAB_W)
	) u_tab (
		.clk      (clk),
		.arst_n   (arst_n),
		.clearing (tab_clearing),
		.wr_en    (tab_wr_en),
		.wr_addr  (tab_wr_addr),
		.wr_data  (tab_wr_data),
		.rd_en    (tab_rd_en),
		.rd_addr  (tab_rd_addr),
		.rd_data  (tab_rd_data)
	);

	bfs_eng #(
		.MAX_NODES      (MAX_NODES),
		.SLOTS_PER_NODE (SLOTS_PER_NODE),
		.NODE_W         (NODE_W),
		.TAB_W          (TAB_W)
	) u_eng (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (eng_req),
		.res_room    (res_room),
		.idle        (eng_idle),
		.tab_rd_en   (tab_rd_en),
		.tab_rd_addr (tab_rd_addr),
		.tab_rd_data (tab_rd_data),
		.res         (eng_res)
	);

	// output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload
	always_ff @(posedge clk) begin
		if (eng_res.done) begin
			hop_count_q <= eng_res.hops;
			reachable_q <= eng_res.reach;
		end
	end

	assign out_valid = out_valid_q;
	assign hop_count = hop_count_q;
	assign reachable = reachable_q;

endmodule

`default_nettype wire
